// ===== src/sfcs_pkg.sv =====
package sfcs_pkg;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_ERASE  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_STATUS = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WRITE = 2'd1;
  localparam logic [1:0] PH_ERASE = 2'd2;

  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_PROG  = 8'h02;
  localparam logic [7:0] OP_ERASE = 8'h20;
  localparam logic [7:0] OP_STAT  = 8'h05;
  localparam logic [7:0] OP_READ  = 8'h03;

  localparam int ADDR_W = 24;
  localparam int LEN_W  = 17;
  localparam int OFF_W  = 16;
  localparam int STAT_W = 8;

  typedef struct packed {
    logic              command_valid;
    logic [7:0]        opcode;
    logic [ADDR_W-1:0] command_address;
    logic [LEN_W-1:0]  transfer_count;
    logic [OFF_W-1:0]  source_offset;
    logic              operation_done;
    logic              request_rejected;
  } row_t;

  localparam row_t ROW_NONE = '0;

endpackage

// ===== src/spi_flash_command_sequencer.sv =====
// Channel  Dir  Carries
// s_*      in   requests (write, erase, read) and status replies
// m_*      out  flash command headers and completion / reject markers
//
// Each transfer in is decoded in the cycle it is taken; its zero, one or three result
// rows are loaded into a three-row output buffer and drained one per cycle
// while m_tready is high. A new transfer is taken while the last buffered row
// is being handed over. Synchronous reset empties the buffer and returns to
// idle. A stall on m_tready holds the buffer and s_tready; s_tready is also
// low whenever more than one row waits.
module spi_flash_command_sequencer import sfcs_pkg::*; #(
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 4096,
  parameter int MAX_LENGTH   = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // start_address, byte_length, status_byte
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // opcode, command_address, transfer_count, source_offset
  output logic [2:0]  m_tuser,   // command_valid, operation_done, request_rejected
  output logic        m_tlast    // run_last
);

  localparam int PG_L   = $clog2(PAGE_BYTES);
  localparam int SB_L   = $clog2(SECTOR_BYTES);
  localparam int SECT_W = $clog2(MAX_LENGTH / SECTOR_BYTES + 3);
  localparam int SUM_W  = 26;

  logic [1:0]        phase, phase_next;
  logic [ADDR_W-1:0] current_address, current_address_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [OFF_W-1:0]  buffer_position, buffer_position_next;
  logic [SECT_W-1:0] sectors_left, sectors_left_next;

  row_t       rows [3];
  row_t       new_rows [3];
  logic [1:0] count, new_count;

  logic [1:0]        mode_in;
  logic [ADDR_W-1:0] addr_in;
  logic [LEN_W-1:0]  len_raw, len_c;
  logic [STAT_W-1:0] stat_in;

  logic [ADDR_W-1:0] base_addr;
  logic [LEN_W-1:0]  base_left;
  logic [OFF_W-1:0]  base_pos;
  logic [SECT_W-1:0] base_sect;
  logic [LEN_W-1:0]  space, chunk;
  logic [SUM_W-1:0]  end_sum;
  logic [SECT_W-1:0] start_sect;

  logic s_take, m_take;
  row_t wren_row, stat_row, prog_row, erase_row, done_row, rej_row, read_row;

  assign mode_in = s_tuser;
  assign addr_in = s_tdata[23:0];
  assign len_raw = s_tdata[40:24];
  assign stat_in = s_tdata[48:41];

  assign len_c = (32'(len_raw) > 32'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len_raw;

  assign m_tvalid = (count != 2'd0);
  assign m_take   = m_tvalid && m_tready;
  assign s_tready = (count == 2'd0) || (count == 2'd1 && m_tready);
  assign s_take   = s_tvalid && s_tready;

  assign m_tdata = {7'd0, rows[0].source_offset, rows[0].transfer_count,
                    rows[0].command_address, rows[0].opcode};
  assign m_tuser = {rows[0].request_rejected, rows[0].operation_done,
                    rows[0].command_valid};
  assign m_tlast = (count == 2'd1);

  // start of the chunk or sector to issue
  always_comb begin
    if (mode_in == MODE_STATUS) begin
      base_addr = current_address;
      base_left = bytes_left;
      base_pos  = buffer_position;
      base_sect = sectors_left;
    end else if (mode_in == MODE_ERASE) begin
      base_addr = addr_in & ~ADDR_W'(SECTOR_BYTES - 1);
      base_left = '0;
      base_pos  = '0;
      base_sect = SECT_W'((end_sum >> SB_L) - SUM_W'(start_sect));
    end else begin
      base_addr = addr_in;
      base_left = len_c;
      base_pos  = '0;
      base_sect = sectors_left;
    end
  end

  assign end_sum    = SUM_W'(addr_in) + SUM_W'(len_c) + SUM_W'(SECTOR_BYTES - 1);
  assign start_sect = SECT_W'(addr_in >> SB_L);
  assign space      = LEN_W'(PAGE_BYTES) - LEN_W'(base_addr[PG_L-1:0]);
  assign chunk      = (base_left < space) ? base_left : space;

  always_comb begin
    wren_row = ROW_NONE;
    wren_row.command_valid = 1'b1;
    wren_row.opcode = OP_WREN;

    stat_row = ROW_NONE;
    stat_row.command_valid = 1'b1;
    stat_row.opcode = OP_STAT;
    stat_row.transfer_count = LEN_W'(1);

    prog_row = ROW_NONE;
    prog_row.command_valid = 1'b1;
    prog_row.opcode = OP_PROG;
    prog_row.command_address = base_addr;
    prog_row.transfer_count = chunk;
    prog_row.source_offset = base_pos;

    erase_row = ROW_NONE;
    erase_row.command_valid = 1'b1;
    erase_row.opcode = OP_ERASE;
    erase_row.command_address = base_addr;

    done_row = ROW_NONE;
    done_row.operation_done = 1'b1;

    rej_row = ROW_NONE;
    rej_row.request_rejected = 1'b1;

    read_row = ROW_NONE;
    read_row.command_valid = 1'b1;
    read_row.opcode = OP_READ;
    read_row.command_address = addr_in;
    read_row.transfer_count = len_c;
    read_row.operation_done = 1'b1;
  end

  always_comb begin
    phase_next           = phase;
    current_address_next = current_address;
    bytes_left_next      = bytes_left;
    buffer_position_next = buffer_position;
    sectors_left_next    = sectors_left;
    new_count            = 2'd0;
    new_rows[0]          = ROW_NONE;
    new_rows[1]          = ROW_NONE;
    new_rows[2]          = ROW_NONE;
    priority if (mode_in == MODE_STATUS) begin
      priority if (phase == PH_IDLE) begin
        new_count = 2'd0;
      end else if (stat_in[0]) begin
        new_count   = 2'd1;
        new_rows[0] = stat_row;
      end else if (phase == PH_WRITE && bytes_left != '0) begin
        new_count            = 2'd3;
        new_rows[0]          = wren_row;
        new_rows[1]          = prog_row;
        new_rows[2]          = stat_row;
        current_address_next = ADDR_W'(base_addr + ADDR_W'(chunk));
        bytes_left_next      = base_left - chunk;
        buffer_position_next = OFF_W'(base_pos + OFF_W'(chunk));
      end else if (phase == PH_ERASE && sectors_left != '0) begin
        new_count            = 2'd3;
        new_rows[0]          = wren_row;
        new_rows[1]          = erase_row;
        new_rows[2]          = stat_row;
        current_address_next = ADDR_W'(base_addr + ADDR_W'(SECTOR_BYTES));
        sectors_left_next    = SECT_W'(base_sect - SECT_W'(1));
      end else begin
        phase_next  = PH_IDLE;
        new_count   = 2'd1;
        new_rows[0] = done_row;
      end
    end else if (phase != PH_IDLE) begin
      new_count   = 2'd1;
      new_rows[0] = rej_row;
    end else if (len_c == '0) begin
      new_count   = 2'd1;
      new_rows[0] = done_row;
    end else if (mode_in == MODE_WRITE) begin
      phase_next           = PH_WRITE;
      new_count            = 2'd3;
      new_rows[0]          = wren_row;
      new_rows[1]          = prog_row;
      new_rows[2]          = stat_row;
      current_address_next = ADDR_W'(base_addr + ADDR_W'(chunk));
      bytes_left_next      = base_left - chunk;
      buffer_position_next = OFF_W'(base_pos + OFF_W'(chunk));
    end else if (mode_in == MODE_ERASE) begin
      phase_next           = PH_ERASE;
      new_count            = 2'd3;
      new_rows[0]          = wren_row;
      new_rows[1]          = erase_row;
      new_rows[2]          = stat_row;
      current_address_next = ADDR_W'(base_addr + ADDR_W'(SECTOR_BYTES));
      sectors_left_next    = SECT_W'(base_sect - SECT_W'(1));
      bytes_left_next      = '0;
      buffer_position_next = '0;
    end else begin
      new_count   = 2'd1;
      new_rows[0] = read_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      current_address <= '0;
      bytes_left      <= '0;
      buffer_position <= '0;
      sectors_left    <= '0;
      count           <= 2'd0;
    end else if (s_take) begin
      phase           <= phase_next;
      current_address <= current_address_next;
      bytes_left      <= bytes_left_next;
      buffer_position <= buffer_position_next;
      sectors_left    <= sectors_left_next;
      count           <= new_count;
    end else if (m_take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      rows[0] <= new_rows[0];
      rows[1] <= new_rows[1];
      rows[2] <= new_rows[2];
    end else if (m_take) begin
      rows[0] <= rows[1];
      rows[1] <= rows[2];
    end
  end

endmodule
